FILE: src/twt_pkg.sv
// Package for the tag whitelist table: field widths, operation and status
// codes, and the sequencer state type.
// No dependencies; used by tag_whitelist_table.
package twt_pkg;

    localparam int TAG_W      = 32;
    localparam int TOP_BYTE_W = 8;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 8;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_PRESENT   = 3'd5,
        ST_ABSENT    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_WRITE = 2'd2,
        S_RESP  = 2'd3
    } state_t;

endpackage

FILE: src/tag_whitelist_table.sv
// Top level of the tag whitelist table: slot memory, scan sequencer with one
// shared compare unit, and the result register.
// Depends on twt_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_ready   | mode, tag_id
//  out     | output    | out_valid / out_ready | status, slot_index
//
// One transaction is handled at a time. The sequencer reads the slot memory
// one slot per cycle through its single read port and compares each slot
// against the key. The scan stops at the first match or after the last slot;
// an add that stores the key or a remove that clears a slot then writes back,
// and the result is held until out_ready.
// Reset needs no clearing pass: a fill mark sits one above the highest slot
// ever written, and slots at or above it read as empty.
// While a result is held, in_ready stays low until the result is taken.
module tag_whitelist_table #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [twt_pkg::MODE_W-1:0]          mode,
    input  logic [twt_pkg::TAG_W-1:0]           tag_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [twt_pkg::STATUS_W-1:0]        status,
    output logic [twt_pkg::SLOT_OUT_W-1:0]      slot_index
);

    // Index width addresses the slots; count width can also hold SLOT_COUNT.
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOT_COUNT);

    // Slot memory. It has no reset; the fill mark covers unwritten slots.
    logic [twt_pkg::TAG_W-1:0] slot_mem [SLOT_COUNT];

    twt_pkg::state_t state_reg, state_next;

    logic [twt_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [twt_pkg::TAG_W-1:0]  key_reg, key_next;

    // Read issue counter and the slot currently in the compare stage.
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             rd_fresh_reg, rd_fresh_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [twt_pkg::TAG_W-1:0] rd_data_reg;

    // Lowest empty slot seen so far in this scan.
    logic             have_empty_reg, have_empty_next;
    logic [IDX_W-1:0] empty_idx_reg, empty_idx_next;

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    twt_pkg::status_t               status_reg, status_next;
    logic [twt_pkg::SLOT_OUT_W-1:0] slot_reg, slot_next;

    logic                      mem_re;
    logic                      mem_we;
    logic [twt_pkg::TAG_W-1:0] mem_wdata;
    logic [twt_pkg::TAG_W-1:0] entry;
    logic                      entry_empty;
    logic                      hit;

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_idx_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= twt_pkg::S_IDLE;
            rd_vld_reg     <= 1'b0;
            have_empty_reg <= 1'b0;
            fill_reg       <= '0;
            issue_cnt_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_vld_reg     <= rd_vld_next;
            have_empty_reg <= have_empty_next;
            fill_reg       <= fill_next;
            issue_cnt_reg  <= issue_cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        rd_fresh_reg  <= rd_fresh_next;
        rd_idx_reg    <= rd_idx_next;
        empty_idx_reg <= empty_idx_next;
        wr_idx_reg    <= wr_idx_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
    end

    // Shared compare unit. A slot at or above the fill mark was never
    // written and reads as empty. Remove only matches slots whose top byte
    // is nonzero.
    always_comb
    begin
        entry       = rd_fresh_reg ? rd_data_reg : '0;
        entry_empty = (entry == '0);
        hit         = (entry == key_reg) &&
                      ((mode_reg != twt_pkg::MODE_REMOVE) ||
                       (entry[twt_pkg::TAG_W-1 -: twt_pkg::TOP_BYTE_W] != '0));
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_vld_next     = rd_vld_reg;
        rd_fresh_next   = rd_fresh_reg;
        rd_idx_next     = rd_idx_reg;
        have_empty_next = have_empty_reg;
        empty_idx_next  = empty_idx_reg;
        wr_idx_next     = wr_idx_reg;
        fill_next       = fill_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        in_ready        = 1'b0;
        out_valid       = 1'b0;

        case (state_reg)
            twt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next       = mode;
                    key_next        = tag_id;
                    issue_cnt_next  = '0;
                    rd_vld_next     = 1'b0;
                    have_empty_next = 1'b0;
                    state_next      = twt_pkg::S_SCAN;
                end
            end

            twt_pkg::S_SCAN:
            begin
                // Issue the next read while the previous slot is compared.
                if (issue_cnt_reg < SLOT_CNT)
                begin
                    mem_re         = 1'b1;
                    rd_vld_next    = 1'b1;
                    rd_fresh_next  = (issue_cnt_reg < fill_reg);
                    rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end

                if (rd_vld_reg)
                begin
                    if (hit)
                    begin
                        rd_vld_next = 1'b0;
                        wr_idx_next = rd_idx_reg;
                        slot_next   = twt_pkg::SLOT_OUT_W'(rd_idx_reg);
                        case (mode_reg)
                            twt_pkg::MODE_ADD:
                            begin
                                status_next = twt_pkg::ST_EXISTS;
                                state_next  = twt_pkg::S_RESP;
                            end
                            twt_pkg::MODE_REMOVE:
                            begin
                                status_next = twt_pkg::ST_REMOVED;
                                state_next  = twt_pkg::S_WRITE;
                            end
                            default:
                            begin
                                status_next = twt_pkg::ST_PRESENT;
                                state_next  = twt_pkg::S_RESP;
                            end
                        endcase
                    end
                    else
                    begin
                        if (entry_empty && !have_empty_reg)
                        begin
                            have_empty_next = 1'b1;
                            empty_idx_next  = rd_idx_reg;
                        end
                        if (rd_idx_reg == LAST_IDX)
                        begin
                            // Scan finished without a match.
                            rd_vld_next = 1'b0;
                            slot_next   = '0;
                            case (mode_reg)
                                twt_pkg::MODE_ADD:
                                begin
                                    if (have_empty_reg || entry_empty)
                                    begin
                                        wr_idx_next = have_empty_reg ? empty_idx_reg
                                                                     : rd_idx_reg;
                                        slot_next   = twt_pkg::SLOT_OUT_W'(wr_idx_next);
                                        status_next = twt_pkg::ST_ADDED;
                                        state_next  = twt_pkg::S_WRITE;
                                    end
                                    else
                                    begin
                                        status_next = twt_pkg::ST_FULL;
                                        state_next  = twt_pkg::S_RESP;
                                    end
                                end
                                twt_pkg::MODE_REMOVE:
                                begin
                                    status_next = twt_pkg::ST_NOT_FOUND;
                                    state_next  = twt_pkg::S_RESP;
                                end
                                default:
                                begin
                                    status_next = twt_pkg::ST_ABSENT;
                                    state_next  = twt_pkg::S_RESP;
                                end
                            endcase
                        end
                    end
                end
            end

            twt_pkg::S_WRITE:
            begin
                // Add stores the key; remove clears the slot.
                mem_we    = 1'b1;
                mem_wdata = (mode_reg == twt_pkg::MODE_ADD) ? key_reg : '0;
                if ((mode_reg == twt_pkg::MODE_ADD) && (CNT_W'(wr_idx_reg) == fill_reg))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = twt_pkg::S_RESP;
            end

            twt_pkg::S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = twt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = twt_pkg::S_IDLE;
            end
        endcase
    end

    assign status     = status_reg;
    assign slot_index = slot_reg;

`ifndef SYNTHESIS
    // The fill mark never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= SLOT_CNT)
        else $error("fill mark beyond table size");

    // Only one transaction is in flight: no input is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && in_ready))
        else $error("input ready while a result is pending");

    // An added identifier always lands below the fill mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == twt_pkg::ST_ADDED)) |-> (CNT_W'(wr_idx_reg) < fill_reg))
        else $error("added slot not covered by fill mark");

    // An accepted transaction starts a scan in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == twt_pkg::S_SCAN && !rd_vld_reg))
        else $error("scan did not start after accept");
`endif

endmodule

FILE: bench/twt_checker.sv
`timescale 1ns / 100ps
// Checker for the tag whitelist table: watches both channels, keeps its own copy of
// the slot table, predicts each result and compares it field by field.
// Depends on twt_pkg.
module twt_checker #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [twt_pkg::MODE_W-1:0]     mode,
    input  logic [twt_pkg::TAG_W-1:0]      tag_id,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [twt_pkg::STATUS_W-1:0]   status,
    input  logic [twt_pkg::SLOT_OUT_W-1:0] slot_index,
    output int                             mismatch_count,
    output int                             answers_waiting
);

    typedef struct packed {
        twt_pkg::status_t                code;
        logic [twt_pkg::SLOT_OUT_W-1:0]  slot;
    } tag_answer_t;

    logic [twt_pkg::TAG_W-1:0] id_slots [SLOT_COUNT];
    tag_answer_t               pending_answers[$];
    int                        errors;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t mismatch: %s, got %0d, expected %0d", $time, what, got, want);
    endtask

    // Lowest slot equal to key, or SLOT_COUNT when none matches. Remove only
    // considers slots whose first UID byte is nonzero.
    function automatic int lowest_match(input logic [twt_pkg::TAG_W-1:0] key,
                                        input bit need_top_byte);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (need_top_byte &&
                id_slots[i][twt_pkg::TAG_W-1 -: twt_pkg::TOP_BYTE_W] == '0)
                continue;
            if (id_slots[i] == key)
                return i;
        end
        return SLOT_COUNT;
    endfunction

    function automatic tag_answer_t apply_request(input logic [twt_pkg::MODE_W-1:0] op,
                                                  input logic [twt_pkg::TAG_W-1:0] key);
        tag_answer_t ans;
        int          hit;
        ans.slot = '0;
        if (op == twt_pkg::MODE_ADD)
        begin
            hit = lowest_match(key, 1'b0);
            if (hit < SLOT_COUNT)
            begin
                ans.code = twt_pkg::ST_EXISTS;
                ans.slot = twt_pkg::SLOT_OUT_W'(hit);
            end
            else
            begin
                hit = lowest_match('0, 1'b0);
                if (hit < SLOT_COUNT)
                begin
                    id_slots[hit] = key;
                    ans.code = twt_pkg::ST_ADDED;
                    ans.slot = twt_pkg::SLOT_OUT_W'(hit);
                end
                else
                begin
                    ans.code = twt_pkg::ST_FULL;
                end
            end
        end
        else if (op == twt_pkg::MODE_REMOVE)
        begin
            hit = lowest_match(key, 1'b1);
            if (hit < SLOT_COUNT)
            begin
                id_slots[hit] = '0;
                ans.code = twt_pkg::ST_REMOVED;
                ans.slot = twt_pkg::SLOT_OUT_W'(hit);
            end
            else
            begin
                ans.code = twt_pkg::ST_NOT_FOUND;
            end
        end
        else
        begin
            // Check, and the unused mode code, which behaves as check.
            hit = lowest_match(key, 1'b0);
            if (hit < SLOT_COUNT)
            begin
                ans.code = twt_pkg::ST_PRESENT;
                ans.slot = twt_pkg::SLOT_OUT_W'(hit);
            end
            else
            begin
                ans.code = twt_pkg::ST_ABSENT;
            end
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        tag_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                id_slots[i] = '0;
            pending_answers.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    report_mismatch("result with nothing expected", status, -1);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (status !== want.code)
                        report_mismatch("status", status, want.code);
                    if (slot_index !== want.slot)
                        report_mismatch("slot_index", slot_index, want.slot);
                end
            end
            if (in_valid && in_ready)
                pending_answers.push_back(apply_request(mode, tag_id));
        end
        mismatch_count  <= errors;
        answers_waiting <= pending_answers.size();
    end

endmodule

FILE: bench/tag_whitelist_table_tb.sv
`timescale 1ns / 100ps
// Testbench top for the tag whitelist table: clock, reset, request stimulus,
// result back-pressure and the final verdict.
// Depends on twt_pkg, tag_whitelist_table and twt_checker.
module tag_whitelist_table_tb;

    localparam int          SLOTS        = 256;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    // Covers a full scan plus write-back, with some margin.
    localparam int          DRAIN_CYCLES = SLOTS + 40;
    localparam int          HOLD_CYCLES  = 400;
    // Slowest run: every transaction a full scan, plus long sender and
    // receiver gaps, taken several times over.
    localparam longint      RUN_LIMIT_NS = 64'd25_000_000;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [twt_pkg::MODE_W-1:0]     mode;
    logic [twt_pkg::TAG_W-1:0]      tag_id;
    logic                           out_valid;
    logic                           out_ready;
    logic [twt_pkg::STATUS_W-1:0]   status;
    logic [twt_pkg::SLOT_OUT_W-1:0] slot_index;

    int mismatch_count;
    int answers_waiting;

    // Shared knobs from the stimulus process to the receiver process. Both are
    // written with nonblocking assignments at the falling edge.
    logic steady;       // when high, neither side idles
    logic hold_toggle;  // each change asks the receiver for one long hold-off

    // IDs that have been offered for adding, to aim later requests at.
    logic [twt_pkg::TAG_W-1:0] offered_ids[$];

    tag_whitelist_table #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .tag_id     (tag_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_index (slot_index)
    );

    twt_checker #(
        .SLOT_COUNT (SLOTS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .tag_id          (tag_id),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot_index      (slot_index),
        .mismatch_count  (mismatch_count),
        .answers_waiting (answers_waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs somewhere.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // Offer one transaction. Called at a falling edge; returns at the falling
    // edge after the transaction was accepted. Valid is left high on return so
    // that back-to-back transactions never lower and raise it in one step; the
    // next call either drops it for an idle cycle or loads the next payload.
    task automatic send_request(input logic [twt_pkg::MODE_W-1:0] op,
                                input logic [twt_pkg::TAG_W-1:0] key);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        tag_id   <= key;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // A fresh ID, usually with a nonzero first UID byte so that it can be removed.
    function automatic logic [twt_pkg::TAG_W-1:0] fresh_id();
        logic [twt_pkg::TAG_W-1:0] id;
        id = $urandom;
        if ($urandom_range(99) < 7)
            id[twt_pkg::TAG_W-1 -: twt_pkg::TOP_BYTE_W] = '0;
        else if (id[twt_pkg::TAG_W-1 -: twt_pkg::TOP_BYTE_W] == '0)
            id[twt_pkg::TAG_W-1 -: twt_pkg::TOP_BYTE_W] = 8'h01;
        return id;
    endfunction

    function automatic logic [twt_pkg::TAG_W-1:0] known_id();
        if (offered_ids.size() == 0)
            return fresh_id();
        return offered_ids[$urandom_range(offered_ids.size() - 1)];
    endfunction

    // One stretch of random traffic. The mix of adds, removes and checks is set
    // per stretch so the table can be driven full, churned there, and drained.
    task automatic random_stretch(input int count, input int add_pct, input int remove_pct);
        int                         pick;
        int                         flavor;
        logic [twt_pkg::TAG_W-1:0]  key;
        logic [twt_pkg::MODE_W-1:0] op;
        for (int n = 0; n < count; n++)
        begin
            pick   = $urandom_range(99);
            flavor = $urandom_range(99);
            if (pick < add_pct)
            begin
                op = twt_pkg::MODE_ADD;
                if (flavor < 88)
                begin
                    key = fresh_id();
                    offered_ids.push_back(key);
                end
                else if (flavor < 93)
                begin
                    key = '0;
                end
                else
                begin
                    key = known_id();
                end
            end
            else if (pick < add_pct + remove_pct)
            begin
                op  = twt_pkg::MODE_REMOVE;
                key = (flavor < 85) ? known_id() : ((flavor < 95) ? fresh_id() : '0);
            end
            else
            begin
                op  = ($urandom_range(99) < 15) ? MODE_UNUSED : twt_pkg::MODE_CHECK;
                key = (flavor < 65) ? known_id() : ((flavor < 90) ? fresh_id() : '0);
            end
            send_request(op, key);
        end
    endtask

    // Receiver: takes results with random stalls, plus one long hold-off on
    // request. During the hold-off the block keeps its result and stops taking
    // new transactions, while the sender keeps offering.
    initial
    begin
        int   hold_left;
        logic seen_toggle;
        hold_left   = 0;
        seen_toggle = 1'b0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(99) < 26)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = twt_pkg::MODE_ADD;
        tag_id      = '0;
        steady      = 1'b0;
        hold_toggle = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part on the empty table. An all-zero ID matches an empty
        // slot, so checking or adding zero finds slot 0.
        send_request(twt_pkg::MODE_CHECK,  32'h0000_0000);
        send_request(twt_pkg::MODE_ADD,    32'h0000_0000);
        send_request(twt_pkg::MODE_ADD,    32'hFFFF_FFFF);
        // An ID with a zero first byte can be added but never removed.
        send_request(twt_pkg::MODE_ADD,    32'h0000_0001);
        send_request(twt_pkg::MODE_ADD,    32'hFFFF_FFFF);
        send_request(twt_pkg::MODE_ADD,    32'h8000_0000);
        send_request(twt_pkg::MODE_CHECK,  32'h0000_0001);
        send_request(twt_pkg::MODE_REMOVE, 32'h0000_0001);
        send_request(twt_pkg::MODE_REMOVE, 32'h1234_5678);
        send_request(twt_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
        send_request(twt_pkg::MODE_CHECK,  32'hFFFF_FFFF);
        // The unused mode code behaves as a check.
        send_request(MODE_UNUSED,          32'h8000_0000);
        send_request(MODE_UNUSED,          32'h0000_0000);
        // The freed slot 0 is reused as the lowest empty slot.
        send_request(twt_pkg::MODE_ADD,    32'h7FFF_FFFF);
        // Removing zero matches nothing: empty slots have a zero first byte.
        send_request(twt_pkg::MODE_REMOVE, 32'h0000_0000);
        send_request(twt_pkg::MODE_ADD,    32'hAAAA_AAAA);
        send_request(twt_pkg::MODE_ADD,    32'h5555_5555);
        send_request(twt_pkg::MODE_CHECK,  32'h5555_5555);
        send_request(twt_pkg::MODE_CHECK,  32'hAAAA_AAAB);
        send_request(twt_pkg::MODE_REMOVE, 32'h8000_0000);
        send_request(twt_pkg::MODE_REMOVE, 32'h8000_0000);
        send_request(twt_pkg::MODE_ADD,    32'h0100_0000);

        // Ask for the long receiver hold-off while the fill traffic starts.
        hold_toggle <= ~hold_toggle;

        // Fill: mostly fresh adds, enough to run the table full and hit the
        // table-full answer, including for the zero ID once no slot is empty.
        random_stretch(360, 90, 5);
        // Churn near full, with a stretch where neither side idles.
        random_stretch(60, 35, 35);
        steady <= 1'b1;
        random_stretch(80, 35, 35);
        steady <= 1'b0;
        random_stretch(40, 35, 35);
        // Drain: mostly removes of known IDs.
        random_stretch(110, 10, 70);

        in_valid <= 1'b0;

        while (answers_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
src/twt_pkg.sv
src/tag_whitelist_table.sv
bench/twt_checker.sv
bench/tag_whitelist_table_tb.sv
